>>> hw/rtl/c2c_pkg.sv
// shared types and constants for the coo to csr converter
// no dependencies
package c2c_pkg;
    localparam int MAX_ROWS    = 256;
    localparam int MAX_ENTRIES = 4096;
    localparam int RW = $clog2(MAX_ROWS);
    localparam int EAW = $clog2(MAX_ENTRIES);
    localparam int PAW = $clog2(MAX_ROWS + 1);
    localparam int CW = 13;
    localparam int ROWW = 8;
    localparam int COLW = 15;
    localparam int VALW = 16;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0, OP_CONVERT = 2'd1, OP_RD_PTR = 2'd2, OP_RD_ENT = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_OK = 3'd0, ST_ROW = 3'd1, ST_FULL = 3'd2, ST_INDEX = 3'd3, ST_NOTCONV = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE, S_RDWAIT, S_CHK_RD, S_CHK, S_CLR, S_CNT_RD, S_CNT_A, S_CNT_B,
        S_PFX_RD, S_PFX, S_SC_RD, S_SC_A, S_SC_B, S_SC_C, S_OUT
    } state_t;
endpackage

>>> hw/rtl/coo_to_csr_converter_core.sv
// coo to csr converter: triple store, convert sequencer and csr read-back
// depends on c2c_pkg and c2c_ram
//
// One command is taken at a time and the input stays blocked until its result
// transfer. An append registers its result directly; a read goes through a
// registered memory read, then the result register. Convert walks the memories
// in passes: a range check over the entries, clearing 257 pointer words, a
// count pass over the entries, a prefix pass over the rows plus one more row
// for the end pointer, and a scatter pass over the entries. Start pointers and
// the per-row running fill share one ram of 257 words; end pointers are copied
// to a second ram of 257 words for the read-back.
module coo_to_csr_converter_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [8:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // opcode, elem_row, elem_col, elem_value, read_index; 54 bits used
    input  logic [55:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status, pointer_or_count, out_col, out_value; 47 bits used
    output logic [47:0] m_tdata
);
    import c2c_pkg::*;

    state_t state_reg, state_next;
    logic [8:0]     num_rows_reg;
    logic [EAW:0]   cnt_reg;          // entry_count
    logic           conv_reg;
    logic [PAW-1:0] conv_rows_reg;
    logic [1:0]     op_reg;
    logic [12:0]    idx_reg;
    logic [EAW:0]   i_reg;
    logic [CW-1:0]  acc_reg;
    logic [ROWW-1:0] row_reg;
    logic [2:0]     st_reg;
    logic [12:0]    ptr_reg;
    logic [COLW-1:0] col_reg;
    logic [VALW-1:0] val_reg;
    logic           mv_reg;

    // triple store
    logic           t_we;
    logic [EAW-1:0] t_waddr, t_raddr;
    logic [ROWW-1:0] tr_rd;
    logic [COLW-1:0] tc_rd;
    logic [VALW-1:0] tv_rd;
    // pointer ram (count, then start, then running fill)
    logic           p_we;
    logic [PAW-1:0] p_waddr, p_raddr;
    logic [CW-1:0]  p_wdata, p_rd;
    // end pointers, kept separately for the read-back
    logic           e_we;
    logic [PAW-1:0] e_waddr, e_raddr;
    logic [CW-1:0]  e_wdata, e_rd;
    // csr store
    logic           c_we;
    logic [EAW-1:0] c_waddr, c_raddr;
    logic [COLW-1:0] cc_rd;
    logic [VALW-1:0] cv_rd;

    logic [1:0]     in_op;
    logic [ROWW-1:0] in_row;
    logic [COLW-1:0] in_col;
    logic [VALW-1:0] in_val;
    logic [12:0]    in_idx;
    logic [PAW-1:0] rows;
    logic           acc_in;

    assign in_op  = s_tdata[1:0];
    assign in_row = s_tdata[9:2];
    assign in_col = s_tdata[24:10];
    assign in_val = s_tdata[40:25];
    assign in_idx = s_tdata[53:41];

    always_comb begin
        if (num_rows_reg == 9'd0) begin
            rows = PAW'(1);
        end else if (32'(num_rows_reg) > MAX_ROWS) begin
            rows = PAW'(MAX_ROWS);
        end else begin
            rows = PAW'(num_rows_reg);
        end
    end

    assign s_tready = (state_reg == S_IDLE) && !mv_reg;
    assign acc_in   = s_tvalid && s_tready;
    assign m_tvalid = mv_reg;
    assign m_tdata  = {1'b0, val_reg, col_reg, ptr_reg, st_reg};

    c2c_ram #(.WIDTH(ROWW), .DEPTH(MAX_ENTRIES)) u_trow (.aclk(aclk), .we(t_we),
        .waddr(t_waddr), .wdata(in_row), .raddr(t_raddr), .rdata(tr_rd));
    c2c_ram #(.WIDTH(COLW), .DEPTH(MAX_ENTRIES)) u_tcol (.aclk(aclk), .we(t_we),
        .waddr(t_waddr), .wdata(in_col), .raddr(t_raddr), .rdata(tc_rd));
    c2c_ram #(.WIDTH(VALW), .DEPTH(MAX_ENTRIES)) u_tval (.aclk(aclk), .we(t_we),
        .waddr(t_waddr), .wdata(in_val), .raddr(t_raddr), .rdata(tv_rd));
    c2c_ram #(.WIDTH(CW), .DEPTH(MAX_ROWS + 1)) u_ptr (.aclk(aclk), .we(p_we),
        .waddr(p_waddr), .wdata(p_wdata), .raddr(p_raddr), .rdata(p_rd));
    c2c_ram #(.WIDTH(CW), .DEPTH(MAX_ROWS + 1)) u_rp (.aclk(aclk), .we(e_we),
        .waddr(e_waddr), .wdata(e_wdata), .raddr(e_raddr), .rdata(e_rd));
    c2c_ram #(.WIDTH(COLW), .DEPTH(MAX_ENTRIES)) u_ccol (.aclk(aclk), .we(c_we),
        .waddr(c_waddr), .wdata(tc_rd), .raddr(c_raddr), .rdata(cc_rd));
    c2c_ram #(.WIDTH(VALW), .DEPTH(MAX_ENTRIES)) u_cval (.aclk(aclk), .we(c_we),
        .waddr(c_waddr), .wdata(tv_rd), .raddr(c_raddr), .rdata(cv_rd));

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (acc_in) begin
                    unique case (opcode_t'(in_op))
                        OP_APPEND:  state_next = S_IDLE;
                        OP_CONVERT: state_next = S_CHK_RD;
                        OP_RD_PTR,
                        OP_RD_ENT:  state_next = S_RDWAIT;
                        default:    state_next = S_IDLE;
                    endcase
                end
            end
            S_RDWAIT: state_next = S_OUT;
            S_CHK_RD: state_next = (i_reg == cnt_reg) ? S_CLR : S_CHK;
            S_CHK:    state_next = (PAW'(tr_rd) >= rows) ? S_IDLE : S_CHK_RD;
            S_CLR:    state_next = (i_reg[PAW-1:0] == PAW'(MAX_ROWS)) ? S_CNT_RD : S_CLR;
            S_CNT_RD: state_next = (i_reg == cnt_reg) ? S_PFX_RD : S_CNT_A;
            S_CNT_A:  state_next = S_CNT_B;
            S_CNT_B:  state_next = S_CNT_RD;
            S_PFX_RD: state_next = S_PFX;
            S_PFX:    state_next = (i_reg[PAW-1:0] == rows) ? S_SC_RD : S_PFX_RD;
            S_SC_RD:  state_next = (i_reg == cnt_reg) ? S_IDLE : S_SC_A;
            S_SC_A:   state_next = S_SC_B;
            S_SC_B:   state_next = S_SC_C;
            S_SC_C:   state_next = S_SC_RD;
            S_OUT:    state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // memory controls
    always_comb begin
        t_we = 1'b0; t_waddr = cnt_reg[EAW-1:0]; t_raddr = i_reg[EAW-1:0];
        p_we = 1'b0; p_waddr = i_reg[PAW-1:0]; p_wdata = '0; p_raddr = i_reg[PAW-1:0];
        e_we = 1'b0; e_waddr = i_reg[PAW-1:0]; e_wdata = acc_reg;
        e_raddr = idx_reg[PAW-1:0];
        c_we = 1'b0; c_waddr = p_rd[EAW-1:0]; c_raddr = idx_reg[EAW-1:0];
        unique case (state_reg)
            S_IDLE: begin
                if (acc_in && opcode_t'(in_op) == OP_APPEND
                    && PAW'(in_row) < rows
                    && (conv_reg || cnt_reg < (EAW+1)'(MAX_ENTRIES))) begin
                    t_we = 1'b1;
                    t_waddr = conv_reg ? '0 : cnt_reg[EAW-1:0];
                end
            end
            S_CLR: p_we = 1'b1;
            S_CNT_A: p_raddr = PAW'(tr_rd) + 1'b1;
            S_CNT_B: begin
                p_we = 1'b1; p_waddr = PAW'(row_reg) + 1'b1; p_wdata = p_rd + 1'b1;
            end
            S_PFX: begin
                // pointer[i] += running sum; end pointer copy for readback
                p_we = 1'b1; p_wdata = p_rd + acc_reg;
                e_we = 1'b1; e_wdata = p_rd + acc_reg;
            end
            S_SC_A: p_raddr = PAW'(tr_rd);
            S_SC_B: begin
                c_we = 1'b1;
                p_we = 1'b1; p_waddr = PAW'(row_reg); p_wdata = p_rd + 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            num_rows_reg <= 9'd256;
            cnt_reg <= '0;
            conv_reg <= 1'b0;
            conv_rows_reg <= '0;
            mv_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                num_rows_reg <= cfg_wdata;
            end
            if (mv_reg && m_tready) begin
                mv_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (acc_in) begin
                        op_reg <= in_op; idx_reg <= in_idx; i_reg <= '0;
                        col_reg <= '0; val_reg <= '0;
                        if (opcode_t'(in_op) == OP_APPEND) begin
                            mv_reg <= 1'b1;
                            conv_reg <= 1'b0;
                            if (PAW'(in_row) >= rows) begin
                                st_reg <= ST_ROW;
                                ptr_reg <= conv_reg ? 13'd0 : 13'(cnt_reg);
                                if (conv_reg) cnt_reg <= '0;
                            end else if (!conv_reg
                                         && cnt_reg >= (EAW+1)'(MAX_ENTRIES)) begin
                                st_reg <= ST_FULL; ptr_reg <= 13'(cnt_reg);
                            end else begin
                                st_reg <= ST_OK;
                                cnt_reg <= conv_reg ? (EAW+1)'(1) : cnt_reg + 1'b1;
                                ptr_reg <= conv_reg ? 13'd1 : 13'(cnt_reg + 1'b1);
                            end
                        end else begin
                            st_reg <= ST_OK; ptr_reg <= '0;
                        end
                    end
                end
                S_CHK: begin
                    if (PAW'(tr_rd) >= rows) begin
                        conv_reg <= 1'b0; st_reg <= ST_ROW; mv_reg <= 1'b1;
                    end else begin
                        i_reg <= i_reg + 1'b1;
                    end
                end
                S_CHK_RD: if (i_reg == cnt_reg) i_reg <= '0;
                S_CLR: begin
                    i_reg <= (i_reg[PAW-1:0] == PAW'(MAX_ROWS)) ? '0 : i_reg + 1'b1;
                end
                S_CNT_RD: begin
                    if (i_reg == cnt_reg) begin
                        i_reg <= '0; acc_reg <= '0;
                    end
                end
                S_CNT_A: row_reg <= tr_rd;
                S_CNT_B: i_reg <= i_reg + 1'b1;
                S_PFX: begin
                    // fill reuses the start pointers; entries past the
                    // last row were cleared and stay untouched
                    acc_reg <= p_rd + acc_reg;
                    i_reg <= (i_reg[PAW-1:0] == rows) ? '0 : i_reg + 1'b1;
                end
                S_SC_RD: begin
                    if (i_reg == cnt_reg) begin
                        conv_reg <= 1'b1; conv_rows_reg <= rows;
                        st_reg <= ST_OK; ptr_reg <= 13'(cnt_reg); mv_reg <= 1'b1;
                    end
                end
                S_SC_A: row_reg <= tr_rd;
                S_SC_B: i_reg <= i_reg + 1'b1;
                S_OUT: begin
                    mv_reg <= 1'b1;
                    if (!conv_reg) begin
                        st_reg <= ST_NOTCONV;
                    end else if (opcode_t'(op_reg) == OP_RD_PTR) begin
                        if (idx_reg > 13'(conv_rows_reg)) st_reg <= ST_INDEX;
                        else ptr_reg <= e_rd;
                    end else begin
                        if (idx_reg >= 13'(cnt_reg)) st_reg <= ST_INDEX;
                        else begin
                            col_reg <= cc_rd; val_reg <= cv_rd;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> state_reg == S_IDLE)
        else $error("ready outside idle");
    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= (EAW+1)'(MAX_ENTRIES))
        else $error("entry count overflow");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (mv_reg && !m_tready) |=> mv_reg && $stable(m_tdata))
        else $error("result dropped");
endmodule

>>> hw/rtl/c2c_ram.sv
// generic single-port-write ram with registered read
// no dependencies
module c2c_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
